// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the I/O port decoder.
// Each macro takes a label, the clock, the synchronous reset and the
// property terms, and reports a violation by $error with the given text.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/hciopd_pkg.sv
// ----------------------------------------------------------------------------
// hciopd_pkg
// Types, port decode constants and sizes of the I/O port decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hciopd_pkg;

   // Storage sizes
   localparam int VRAM_BYTES = 8192;
   localparam int VRAM_AW    = $clog2(VRAM_BYTES);
   localparam int KEY_ROWS   = 10;
   localparam int KEY_AW     = $clog2(KEY_ROWS);
   localparam logic [4:0] KEY_LIMIT = 5'(KEY_ROWS);

   // Configuration port
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;
   localparam int CSR_IDXW = 2;
   localparam logic [CSR_IDXW-1:0] REG_PLAY_BUTTON = 2'd0;
   localparam logic [CSR_IDXW-1:0] REG_WIN_LOW     = 2'd1;
   localparam logic [CSR_IDXW-1:0] REG_WIN_HIGH    = 2'd2;

   localparam logic [15:0] WIN_LOW_RESET  = 16'h02E0;
   localparam logic [15:0] WIN_HIGH_RESET = 16'h0370;

   // Item commands
   localparam logic [1:0] CMD_READ    = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_KEY     = 2'd2;
   localparam logic [1:0] CMD_SYSRST  = 2'd3;

   // Port decode
   localparam logic [15:0] GRP_MASK     = 16'hE000;
   localparam logic [15:0] GRP_VRAM     = 16'h0000;
   localparam logic [15:0] GRP_MODE     = 16'h2000;
   localparam logic [15:0] GRP_MOTOR    = 16'h6000;
   localparam logic [15:0] GRP_OVERLAY  = 16'hA000;
   localparam logic [11:0] KEY_PAGE     = 12'h800;
   localparam logic [15:0] PSG_MASK     = 16'hFFFE;
   localparam logic [15:0] PORT_PSG     = 16'h4000;
   localparam logic [15:0] PORT_TAPE    = 16'h4003;

   localparam logic [7:0] BYTE_ONES     = 8'hFF;
   localparam logic [7:0] PSG_ADDR_READ = 8'h1F;
   localparam logic [4:0] PSG_REG_MASK_W = 5'h1F;
   localparam logic [4:0] PSG_REG_TAPE  = 5'd14;
   localparam int TAPE_BIT_POS  = 7;
   localparam int MOTOR_BIT_POS = 6;
   localparam int PULSE_BIT_POS = 1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] port;
      logic [7:0]  wdata;
      logic [3:0]  key_row;
      logic        tape_bit;
      logic        tape_present;
      logic [7:0]  psg_rdata;
      logic [15:0] cpu_pc;
   } req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       psg_write_strobe;
      logic       psg_data_sel;
      logic       tape_taken;
      logic       motor_start;
      logic       motor_on;
      logic       rom_overlay;
   } rsp_type;

   typedef struct packed {
      logic        play_button_down;
      logic [15:0] check_window_low;
      logic [15:0] check_window_high;
   } cfg_type;

   typedef struct packed {
      logic               we;
      logic [VRAM_AW-1:0] addr;
      logic [7:0]         data;
   } vram_wr_type;

endpackage

`default_nettype wire

// File: rtl/hciopd_ram.sv
// ----------------------------------------------------------------------------
// hciopd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hciopd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/hciopd_csr.sv
// ----------------------------------------------------------------------------
// hciopd_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hciopd_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [hciopd_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [hciopd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [hciopd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                                 csr_pready,
   input  wire logic                            set_play,
   output hciopd_pkg::cfg_type                  cfg
);

   logic                                wr_en;
   logic [hciopd_pkg::CSR_IDXW-1:0]     idx;
   logic                                play_ff, play_in;
   logic [15:0]                         win_low_ff, win_low_in;
   logic [15:0]                         win_high_ff, win_high_in;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx   = csr_paddr[hciopd_pkg::CSR_AW-1:2];

   always_comb begin
      play_in     = play_ff;
      win_low_in  = win_low_ff;
      win_high_in = win_high_ff;
      if (set_play) begin
         play_in = 1'b1;
      end
      if (wr_en) begin
         case (idx)
            hciopd_pkg::REG_PLAY_BUTTON: play_in     = csr_pwdata[0];
            hciopd_pkg::REG_WIN_LOW:     win_low_in  = csr_pwdata[15:0];
            hciopd_pkg::REG_WIN_HIGH:    win_high_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_ff     <= 1'b1;
         win_low_ff  <= hciopd_pkg::WIN_LOW_RESET;
         win_high_ff <= hciopd_pkg::WIN_HIGH_RESET;
      end else begin
         play_ff     <= play_in;
         win_low_ff  <= win_low_in;
         win_high_ff <= win_high_in;
      end
   end

   always_comb begin
      case (idx)
         hciopd_pkg::REG_PLAY_BUTTON: csr_prdata = {31'b0, play_ff};
         hciopd_pkg::REG_WIN_LOW:     csr_prdata = {16'b0, win_low_ff};
         hciopd_pkg::REG_WIN_HIGH:    csr_prdata = {16'b0, win_high_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   assign cfg.play_button_down  = play_ff;
   assign cfg.check_window_low  = win_low_ff;
   assign cfg.check_window_high = win_high_ff;

endmodule

`default_nettype wire

// File: rtl/hciopd_exec.sv
// ----------------------------------------------------------------------------
// hciopd_exec
// Port decode and small state of the decoder: one item per fire.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hciopd_exec (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire hciopd_pkg::req_type  item,
   input  wire logic [7:0]           vram_rdata,
   input  wire hciopd_pkg::cfg_type  cfg,
   output hciopd_pkg::rsp_type       rsp,
   output hciopd_pkg::vram_wr_type   vram_wr,
   output logic                      set_play
);

   logic [7:0] key_rows_ff [hciopd_pkg::KEY_ROWS];
   logic [7:0] key_rows_in [hciopd_pkg::KEY_ROWS];
   logic       overlay_ff, overlay_in;
   logic [7:0] mode_ff, mode_in;
   logic [4:0] psg_reg_ff, psg_reg_in;
   logic       motor_ff, motor_in;
   logic       pulse_ff, pulse_in;

   logic [15:0] grp;
   logic        key_hit;
   logic        psg_hit;
   logic        in_win;

   always_comb begin
      grp     = item.port & hciopd_pkg::GRP_MASK;
      key_hit = (item.port[15:4] == hciopd_pkg::KEY_PAGE)
                && ({1'b0, item.port[3:0]} < hciopd_pkg::KEY_LIMIT);
      psg_hit = (item.port & hciopd_pkg::PSG_MASK) == hciopd_pkg::PORT_PSG;
      in_win  = (item.cpu_pc >= cfg.check_window_low)
                && (item.cpu_pc <= cfg.check_window_high);

      key_rows_in = key_rows_ff;
      overlay_in  = overlay_ff;
      mode_in     = mode_ff;
      psg_reg_in  = psg_reg_ff;
      motor_in    = motor_ff;
      pulse_in    = pulse_ff;
      vram_wr     = '0;
      set_play    = 1'b0;
      rsp         = '0;
      rsp.rdata   = hciopd_pkg::BYTE_ONES;

      case (item.cmd)
         hciopd_pkg::CMD_READ: begin
            if (key_hit) begin
               rsp.rdata = key_rows_ff[item.port[hciopd_pkg::KEY_AW-1:0]];
            end else if (grp == hciopd_pkg::GRP_OVERLAY) begin
               overlay_in = !overlay_ff;
            end else if (grp == hciopd_pkg::GRP_MODE) begin
               rsp.rdata = mode_ff;
            end else if (grp == hciopd_pkg::GRP_VRAM) begin
               rsp.rdata = vram_rdata;
            end else if (psg_hit) begin
               rsp.psg_data_sel = item.port[0];
               if (!item.port[0]) begin
                  rsp.rdata = hciopd_pkg::PSG_ADDR_READ;
               end else if (psg_reg_ff == hciopd_pkg::PSG_REG_TAPE) begin
                  // cassette status: tape bit in bit 7, motor off in bit 6
                  if (cfg.play_button_down && motor_ff) begin
                     if (!in_win) begin
                        rsp.tape_taken = 1'b1;
                        rsp.rdata[hciopd_pkg::TAPE_BIT_POS] = item.tape_bit;
                     end
                     rsp.rdata[hciopd_pkg::MOTOR_BIT_POS] = 1'b0;
                  end
               end else begin
                  rsp.rdata = item.psg_rdata;
               end
            end else if (item.port == hciopd_pkg::PORT_TAPE) begin
               rsp.rdata = {7'b0, item.tape_present};
            end
         end
         hciopd_pkg::CMD_WRITE: begin
            if (grp == hciopd_pkg::GRP_VRAM) begin
               vram_wr.we   = 1'b1;
               vram_wr.addr = item.port[hciopd_pkg::VRAM_AW-1:0];
               vram_wr.data = item.wdata;
            end else if (grp == hciopd_pkg::GRP_OVERLAY) begin
               overlay_in = !overlay_ff;
            end else if (grp == hciopd_pkg::GRP_MODE) begin
               mode_in = item.wdata;
            end else if (grp == hciopd_pkg::GRP_MOTOR) begin
               if (cfg.play_button_down) begin
                  if (item.wdata[hciopd_pkg::PULSE_BIT_POS]) begin
                     pulse_in = 1'b1;
                  end else if (pulse_ff) begin
                     // falling pulse edge: toggle the motor
                     pulse_in = 1'b0;
                     motor_in = !motor_ff;
                     if (!motor_ff) begin
                        overlay_in = 1'b0;
                     end
                  end
               end
            end else if (item.port == hciopd_pkg::PORT_TAPE) begin
               if (item.wdata == 8'd0) begin
                  set_play   = 1'b1;
                  motor_in   = 1'b1;
                  overlay_in = 1'b0;
               end
            end else if (psg_hit) begin
               rsp.psg_write_strobe = 1'b1;
               rsp.psg_data_sel     = item.port[0];
               if (!item.port[0]) begin
                  psg_reg_in = item.wdata[4:0] & hciopd_pkg::PSG_REG_MASK_W;
               end
            end
         end
         hciopd_pkg::CMD_KEY: begin
            if ({1'b0, item.key_row} < hciopd_pkg::KEY_LIMIT) begin
               key_rows_in[item.key_row[hciopd_pkg::KEY_AW-1:0]] = item.wdata;
            end
         end
         default: begin
            overlay_in = 1'b1;
            motor_in   = 1'b0;
            pulse_in   = 1'b0;
            for (int i = 0; i < hciopd_pkg::KEY_ROWS; i++) begin
               key_rows_in[i] = hciopd_pkg::BYTE_ONES;
            end
         end
      endcase

      rsp.motor_start = !motor_ff && motor_in;
      rsp.motor_on    = motor_in;
      rsp.rom_overlay = overlay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overlay_ff <= 1'b1;
         mode_ff    <= '0;
         psg_reg_ff <= '0;
         motor_ff   <= 1'b0;
         pulse_ff   <= 1'b0;
         for (int i = 0; i < hciopd_pkg::KEY_ROWS; i++) begin
            key_rows_ff[i] <= hciopd_pkg::BYTE_ONES;
         end
      end else if (fire) begin
         overlay_ff  <= overlay_in;
         mode_ff     <= mode_in;
         psg_reg_ff  <= psg_reg_in;
         motor_ff    <= motor_in;
         pulse_ff    <= pulse_in;
         key_rows_ff <= key_rows_in;
      end
   end

   `ASSERT_IMPLIES(a_start_means_on, clock, reset, fire && rsp.motor_start, rsp.motor_on, "motor start without motor on")
   `ASSERT_IMPLIES(a_taken_needs_motor, clock, reset, fire && rsp.tape_taken, motor_ff && cfg.play_button_down, "tape bit taken with motor idle")
   `ASSERT_IMPLIES(a_strobe_on_write, clock, reset, fire && (rsp.psg_write_strobe || vram_wr.we), item.cmd == hciopd_pkg::CMD_WRITE, "write side effect from non-write item")

endmodule

`default_nettype wire

// File: rtl/home_computer_io_port_decoder.sv
// ----------------------------------------------------------------------------
// home_computer_io_port_decoder
// I/O port decoder of an 8-bit home computer with an 8 KB video RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one processor access per item: port read, port write,
//          keyboard row update or system reset, together with the tape,
//          sound-chip and program counter inputs sampled for that access.
//   rsp_*  returns exactly one item per request: read byte, sound-chip
//          strobe and select, tape consumption and the motor/overlay state.
//   csr_*  APB-style port for the play button and motor-check window
//          registers at byte addresses 0, 4 and 8; pready is always high.
// Timing: the video RAM read is registered at the taking edge, together
//   with the item in the decode stage; decode and update then run from
//   that stage and land in the output register once it is free.
// Throughput: one item per cycle while the receiver keeps up; the rate is
//   set by the single video RAM read port, issued when the item is taken.
// Reset: a clearing pass writes zero to all 8192 video RAM bytes, one byte
//   a cycle; req_ready stays low until the pass is done.
// Stall: with rsp_ready low, one result waits in the output register and
//   one more item is held at the decode stage before req_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module home_computer_io_port_decoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire hciopd_pkg::req_type             req_item,
   // result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output hciopd_pkg::rsp_type                  rsp_item,
   // configuration port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [hciopd_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [hciopd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [hciopd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int AW = hciopd_pkg::VRAM_AW;

   // decode stage
   hciopd_pkg::req_type     item_ff, item_in;
   logic                    busy_ff, busy_in;
   // output register
   hciopd_pkg::rsp_type     rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   // video RAM clearing pass
   logic                    clear_ff, clear_in;
   logic [AW-1:0]           clear_addr_ff, clear_addr_in;
   // write-to-read forwarding
   logic                    fwd_ff, fwd_in;
   logic [7:0]              fwd_data_ff, fwd_data_in;

   logic                    accept;
   logic                    exec_fire;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [7:0]              ram_wdata;
   logic [7:0]              ram_rdata;
   logic [7:0]              vram_q;
   logic                    set_play;
   hciopd_pkg::cfg_type     cfg;
   hciopd_pkg::rsp_type     exec_rsp;
   hciopd_pkg::vram_wr_type vram_wr;

   // Advance the decode stage when the output register is free or drains now.
   assign exec_fire = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clear_ff && (!busy_ff || exec_fire);
   assign accept    = req_valid && req_ready;

   always_comb begin
      item_in      = accept ? req_item : item_ff;
      busy_in      = accept ? 1'b1 : (exec_fire ? 1'b0 : busy_ff);
      rsp_in       = exec_fire ? exec_rsp : rsp_ff;
      rsp_valid_in = exec_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Hold a forwarded byte when the item in decode writes the address that
   // the newly taken item reads in the same cycle.
   always_comb begin
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (accept) begin
         fwd_in      = exec_fire && vram_wr.we && (vram_wr.addr == req_item.port[AW-1:0]);
         fwd_data_in = vram_wr.data;
      end
   end

   // Sweep the video RAM to zero after reset.
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == AW'(hciopd_pkg::VRAM_BYTES - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         fwd_ff        <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         fwd_ff        <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_ff      <= rsp_in;
      fwd_data_ff <= fwd_data_in;
   end

   assign ram_we    = clear_ff || (exec_fire && vram_wr.we);
   assign ram_waddr = clear_ff ? clear_addr_ff : vram_wr.addr;
   assign ram_wdata = clear_ff ? 8'd0 : vram_wr.data;
   assign vram_q    = fwd_ff ? fwd_data_ff : ram_rdata;

   hciopd_ram #(
      .WIDTH (8),
      .DEPTH (hciopd_pkg::VRAM_BYTES)
   ) u_vram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (req_item.port[AW-1:0]),
      .rdata (ram_rdata)
   );

   // The play button is pressed only when the tape port write actually fires.
   hciopd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .set_play    (set_play && exec_fire),
      .cfg         (cfg)
   );

   hciopd_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .fire       (exec_fire),
      .item       (item_ff),
      .vram_rdata (vram_q),
      .cfg        (cfg),
      .rsp        (exec_rsp),
      .vram_wr    (vram_wr),
      .set_play   (set_play)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_IMPLIES(a_idle_while_clearing, clock, reset, clear_ff, !busy_ff && !rsp_valid_ff, "item in flight during video RAM clear")
   `ASSERT_NEXT(a_accept_loads_stage, clock, reset, accept, busy_ff, "taken item not held in decode stage")
   `ASSERT_NEXT(a_fire_loads_output, clock, reset, exec_fire, rsp_valid_ff, "decoded item lost before output register")
   `ASSERT_NEXT(a_stall_holds_item, clock, reset, busy_ff && !exec_fire, busy_ff, "stalled item dropped from decode stage")

endmodule

`default_nettype wire

// File: tb/home_computer_io_port_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// home_computer_io_port_decoder_test
// Self-checking bench for the I/O port decoder. A shadow copy of the video
// RAM, key rows, overlay, mode, sound register and cassette latches predicts
// every result item, and the results are checked field by field in order.
// Directed items cover the decode corners. Window and play button settings
// are then swept, the receiver is held off for a long stretch, and three
// random phases run with different idling on both channels.
// ----------------------------------------------------------------------------
module home_computer_io_port_decoder_test;
   import hciopd_pkg::*;

   localparam int          CLOCK_HALF_NS   = 10;
   localparam int          RESET_CYCLES    = 9;
   localparam int          TIMEOUT_NS      = 4_000_000;
   localparam int          TAIL_CYCLES     = 10;
   localparam int          RSP_HOLD_CYCLES = 300;
   localparam int          MAX_REPORTS     = 10;
   localparam logic [15:0] KEY_PORT_BASE   = 16'h8000;
   localparam logic [15:0] PORT_UNUSED     = 16'hFFFF;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_item    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_item;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // Idling odds, in cycles per hundred, and the long receiver hold-off
   int unsigned send_idle_pct = 12;
   int unsigned rsp_idle_pct  = 86;
   logic        rsp_hold      = 1'b0;
   event        hold_trigger;

   // Shadow of the decoder state and of its registers
   logic [7:0]  shadow_vram [VRAM_BYTES];
   logic [7:0]  shadow_keys [KEY_ROWS];
   logic        shadow_overlay;
   logic [7:0]  shadow_mode;
   logic [4:0]  shadow_psg_reg;
   logic        shadow_motor;
   logic        shadow_pulse;
   cfg_type     shadow_cfg;

   // Results owed by the decoder, oldest first
   rsp_type     predicted_rsp [$];
   int unsigned failures  = 0;
   int unsigned rsp_count = 0;

   home_computer_io_port_decoder i_dut (.*);

   always #(CLOCK_HALF_NS) clock = ~clock;

   // Abandon the run if the decoder stops making progress
   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction: apply one accepted item to the shadow state and return the
   // result item it must produce.
   // ------------------------------------------------------------------------
   function automatic rsp_type decode_access(req_type it);
      rsp_type     r;
      logic        motor_was;
      logic [15:0] grp;
      int          key_idx;
      r         = '0;
      r.rdata   = BYTE_ONES;
      motor_was = shadow_motor;
      grp       = it.port & GRP_MASK;
      key_idx   = int'(it.port) - int'(KEY_PORT_BASE);
      case (it.cmd)
         CMD_READ: begin
            if (key_idx >= 0 && key_idx < KEY_ROWS) begin
               r.rdata = shadow_keys[key_idx];
            end else if (grp == GRP_OVERLAY) begin
               shadow_overlay = ~shadow_overlay;
            end else if (grp == GRP_MODE) begin
               r.rdata = shadow_mode;
            end else if (grp == GRP_VRAM) begin
               r.rdata = shadow_vram[it.port[VRAM_AW-1:0]];
            end else if ((it.port & PSG_MASK) == PORT_PSG) begin
               r.psg_data_sel = it.port[0];
               if (!it.port[0]) begin
                  r.rdata = PSG_ADDR_READ;
               end else if (shadow_psg_reg == PSG_REG_TAPE) begin
                  // cassette status: all ones unless the button is down and the motor runs
                  if (shadow_cfg.play_button_down && shadow_motor) begin
                     r.rdata[MOTOR_BIT_POS] = 1'b0;
                     if (it.cpu_pc < shadow_cfg.check_window_low ||
                         it.cpu_pc > shadow_cfg.check_window_high) begin
                        r.tape_taken           = 1'b1;
                        r.rdata[TAPE_BIT_POS] = it.tape_bit;
                     end
                  end
               end else begin
                  r.rdata = it.psg_rdata;
               end
            end else if (it.port == PORT_TAPE) begin
               r.rdata = {7'd0, it.tape_present};
            end
         end
         CMD_WRITE: begin
            if (grp == GRP_VRAM) begin
               shadow_vram[it.port[VRAM_AW-1:0]] = it.wdata;
            end else if (grp == GRP_OVERLAY) begin
               shadow_overlay = ~shadow_overlay;
            end else if (grp == GRP_MODE) begin
               shadow_mode = it.wdata;
            end else if (grp == GRP_MOTOR) begin
               // the motor toggles on the falling edge of the pulse bit
               if (shadow_cfg.play_button_down) begin
                  if (it.wdata[PULSE_BIT_POS]) begin
                     shadow_pulse = 1'b1;
                  end else if (shadow_pulse) begin
                     shadow_pulse = 1'b0;
                     shadow_motor = ~shadow_motor;
                     if (shadow_motor) begin
                        shadow_overlay = 1'b0;
                     end
                  end
               end
            end else if (it.port == PORT_TAPE) begin
               if (it.wdata == 8'd0) begin
                  shadow_cfg.play_button_down = 1'b1;
                  shadow_motor                = 1'b1;
                  shadow_overlay              = 1'b0;
               end
            end else if ((it.port & PSG_MASK) == PORT_PSG) begin
               r.psg_write_strobe = 1'b1;
               r.psg_data_sel     = it.port[0];
               if (!it.port[0]) begin
                  shadow_psg_reg = it.wdata[4:0] & PSG_REG_MASK_W;
               end
            end
         end
         CMD_KEY: begin
            if (it.key_row < KEY_ROWS) begin
               shadow_keys[it.key_row] = it.wdata;
            end
         end
         CMD_SYSRST: begin
            shadow_overlay = 1'b1;
            foreach (shadow_keys[i]) shadow_keys[i] = BYTE_ONES;
            shadow_motor = 1'b0;
            shadow_pulse = 1'b0;
         end
      endcase
      r.motor_start = !motor_was && shadow_motor;
      r.motor_on    = shadow_motor;
      r.rom_overlay = shadow_overlay;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random ready, with a hold-off stretch on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Hold the receiver off for a fixed count of cycles each time it is asked
   initial begin
      forever begin
         @(hold_trigger);
         rsp_hold <= 1'b1;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= MAX_REPORTS) begin
            $display("result %0d field %s: expected %02h, got %02h",
                     rsp_count, field, want, got);
         end
      end
   endfunction

   // Check every accepted result item against the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (rsp_valid && rsp_ready) begin
         rsp_count++;
         if (predicted_rsp.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("result %0d arrived with none owed: rdata %02h",
                        rsp_count, rsp_item.rdata);
            end
         end else begin
            want = predicted_rsp.pop_front();
            compare_field("rdata", want.rdata, rsp_item.rdata);
            compare_field("psg_write_strobe", want.psg_write_strobe,
                          rsp_item.psg_write_strobe);
            compare_field("psg_data_sel", want.psg_data_sel, rsp_item.psg_data_sel);
            compare_field("tape_taken", want.tape_taken, rsp_item.tape_taken);
            compare_field("motor_start", want.motor_start, rsp_item.motor_start);
            compare_field("motor_on", want.motor_on, rsp_item.motor_on);
            compare_field("rom_overlay", want.rom_overlay, rsp_item.rom_overlay);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Fill the side inputs of an item at random
   function automatic req_type make_item(logic [1:0] cmd, logic [15:0] port,
                                         logic [7:0] wdata);
      req_type it;
      it.cmd          = cmd;
      it.port         = port;
      it.wdata        = wdata;
      it.key_row      = 4'($urandom_range(15));
      it.tape_bit     = 1'($urandom_range(1));
      it.tape_present = 1'($urandom_range(1));
      it.psg_rdata    = 8'($urandom_range(255));
      it.cpu_pc       = 16'($urandom_range(65535));
      return it;
   endfunction

   // Offer one item, idling first at random; valid stays high for a following item
   task automatic send_item(req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted_rsp.push_back(decode_access(it));
   endtask

   task automatic send_access(logic [1:0] cmd, logic [15:0] port, logic [7:0] wdata);
      send_item(make_item(cmd, port, wdata));
   endtask

   // Read the cassette status byte at a given PC and tape bit
   task automatic send_status_read(logic [15:0] pc, logic tape);
      req_type it;
      it          = make_item(CMD_READ, PORT_PSG | 16'd1, 8'd0);
      it.cpu_pc   = pc;
      it.tape_bit = tape;
      send_item(it);
   endtask

   // Drop valid and wait until every owed result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_rsp.size() != 0) @(posedge clock);
   endtask

   // APB write: setup, then access; the register takes it when pready is high
   task automatic write_register(logic [CSR_IDXW-1:0] idx, logic [31:0] value);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_PLAY_BUTTON: shadow_cfg.play_button_down  = value[0];
         REG_WIN_LOW:     shadow_cfg.check_window_low  = value[15:0];
         REG_WIN_HIGH:    shadow_cfg.check_window_high = value[15:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Decode corners at the reset register settings
   task automatic test_directed_decode();
      req_type it;
      // last key row, then a row index past the end which must be ignored
      it         = make_item(CMD_KEY, 16'd0, 8'h00);
      it.key_row = 4'(KEY_ROWS - 1);
      send_item(it);
      it         = make_item(CMD_KEY, 16'd0, 8'h12);
      it.key_row = 4'd15;
      send_item(it);
      send_access(CMD_READ, KEY_PORT_BASE, 8'd0);
      send_access(CMD_READ, KEY_PORT_BASE + 16'(KEY_ROWS - 1), 8'd0);
      send_access(CMD_READ, KEY_PORT_BASE + 16'(KEY_ROWS), 8'd0);
      // video RAM at both ends
      send_access(CMD_WRITE, 16'h0000, 8'hFF);
      send_access(CMD_WRITE, 16'h1FFF, 8'hA5);
      send_access(CMD_READ, 16'h0000, 8'd0);
      send_access(CMD_READ, 16'h1FFF, 8'd0);
      // mode byte and overlay group, across their port ranges
      send_access(CMD_WRITE, GRP_MODE, 8'h80);
      send_access(CMD_READ, GRP_MODE | 16'h1FFF, 8'd0);
      send_access(CMD_READ, GRP_OVERLAY, 8'd0);
      send_access(CMD_WRITE, GRP_OVERLAY | 16'h1FFF, 8'd0);
      // select sound register 14 through a byte with upper bits set
      send_access(CMD_WRITE, PORT_PSG, 8'hEE);
      send_access(CMD_READ, PORT_PSG, 8'd0);
      send_status_read(16'h0000, 1'b0);
      // pulse high then low: motor on, overlay cleared
      send_access(CMD_WRITE, GRP_MOTOR, 8'h02);
      send_access(CMD_WRITE, GRP_MOTOR | 16'h1FFF, 8'hFD);
      send_status_read(WIN_LOW_RESET + 16'h20, 1'b0);
      send_status_read(16'h0000, 1'b0);
      send_status_read(16'hFFFF, 1'b1);
      send_access(CMD_WRITE, PORT_PSG | 16'd1, 8'h55);
      // system reset, then force the motor on through the tape port
      send_access(CMD_SYSRST, 16'd0, 8'd0);
      send_access(CMD_WRITE, PORT_TAPE, 8'h01);
      send_access(CMD_WRITE, PORT_TAPE, 8'h00);
      send_access(CMD_READ, PORT_TAPE, 8'd0);
      send_access(CMD_READ, PORT_UNUSED, 8'd0);
   endtask

   // Sweep the check window and the play button, extremes included
   task automatic test_check_window();
      // empty window: every PC takes a tape bit
      write_register(REG_WIN_LOW, 32'hFFFF);
      write_register(REG_WIN_HIGH, 32'h0000);
      send_access(CMD_WRITE, PORT_PSG, {3'd0, PSG_REG_TAPE});
      send_access(CMD_WRITE, PORT_TAPE, 8'h00);
      send_status_read(16'hFFFF, 1'b0);
      send_status_read(16'h0000, 1'b1);
      send_status_read(16'h0300, 1'b0);
      // full window: no PC takes a bit
      write_register(REG_WIN_LOW, 32'h0000);
      write_register(REG_WIN_HIGH, 32'hFFFF);
      send_status_read(16'h0000, 1'b0);
      send_status_read(16'hFFFF, 1'b0);
      // single-PC window, probed on and beside it
      write_register(REG_WIN_LOW, 32'h1234);
      write_register(REG_WIN_HIGH, 32'h1234);
      send_status_read(16'h1233, 1'b0);
      send_status_read(16'h1234, 1'b0);
      send_status_read(16'h1235, 1'b1);
      // button up: status reads all ones and motor pulses do nothing
      write_register(REG_PLAY_BUTTON, 32'd0);
      send_status_read(16'h1000, 1'b0);
      send_access(CMD_WRITE, GRP_MOTOR, 8'h02);
      send_access(CMD_WRITE, GRP_MOTOR, 8'h00);
      // a zero at the tape port presses the button again
      send_access(CMD_WRITE, PORT_TAPE, 8'h00);
      send_status_read(16'h1000, 1'b0);
      write_register(REG_PLAY_BUTTON, 32'd1);
      write_register(REG_WIN_LOW, 32'(WIN_LOW_RESET));
      write_register(REG_WIN_HIGH, 32'(WIN_HIGH_RESET));
   endtask

   // Hold the receiver off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      int unsigned n;
      send_idle_pct = 0;
      -> hold_trigger;
      for (n = 0; n < 24; n++) begin
         send_access(($urandom_range(1) != 0) ? CMD_WRITE : CMD_READ,
                     16'($urandom_range(15)), 8'($urandom_range(255)));
      end
      // pause the sender until everything owed is back
      drain_results();
   endtask

   // Mostly well-formed sequences with random content, plus some noise
   task automatic test_random_traffic(int unsigned item_total);
      req_type     it;
      int unsigned sent;
      int unsigned kind;
      logic [15:0] pc_base;
      write_register(REG_PLAY_BUTTON, 32'($urandom_range(99) < 80));
      write_register(REG_WIN_LOW, $urandom_range(65535));
      write_register(REG_WIN_HIGH, $urandom_range(65535));
      sent = 0;
      while (sent < item_total) begin
         kind = $urandom_range(99);
         it   = make_item(CMD_READ, 16'($urandom_range(65535)), 8'($urandom_range(255)));
         if (kind < 18) begin
            // video RAM, often on a few bytes so reads meet earlier writes
            it.cmd  = ($urandom_range(1) != 0) ? CMD_WRITE : CMD_READ;
            it.port = 16'($urandom_range(8191));
            if ($urandom_range(1) != 0) it.port = 16'($urandom_range(31));
         end else if (kind < 32) begin
            // motor pulse: raise bit 1, then drop it somewhere in the group
            it.cmd                   = CMD_WRITE;
            it.port                  = GRP_MOTOR | 16'($urandom_range(8191));
            it.wdata[PULSE_BIT_POS] = 1'b1;
            send_item(it);
            sent++;
            it = make_item(CMD_WRITE, GRP_MOTOR | 16'($urandom_range(8191)),
                           8'($urandom_range(255)));
            it.wdata[PULSE_BIT_POS] = 1'b0;
         end else if (kind < 48) begin
            // cassette status, mostly after selecting register 14, PC mostly near the window edges
            if ($urandom_range(3) != 0) begin
               send_access(CMD_WRITE, PORT_PSG, {3'($urandom_range(7)), PSG_REG_TAPE});
               sent++;
            end
            it.port = PORT_PSG | 16'd1;
            case ($urandom_range(2))
               0:       pc_base = shadow_cfg.check_window_low;
               1:       pc_base = shadow_cfg.check_window_high;
               default: pc_base = it.cpu_pc;
            endcase
            it.cpu_pc = pc_base + 16'($urandom_range(4)) - 16'd2;
         end else if (kind < 58) begin
            // key row update followed by a read around the row ports
            it.cmd = CMD_KEY;
            send_item(it);
            sent++;
            it = make_item(CMD_READ, KEY_PORT_BASE + 16'($urandom_range(KEY_ROWS + 1)), 8'd0);
         end else if (kind < 66) begin
            it.cmd  = ($urandom_range(1) != 0) ? CMD_WRITE : CMD_READ;
            it.port = (($urandom_range(1) != 0) ? GRP_MODE : GRP_OVERLAY)
                      | 16'($urandom_range(8191));
         end else if (kind < 74) begin
            it.cmd  = ($urandom_range(1) != 0) ? CMD_WRITE : CMD_READ;
            it.port = PORT_PSG | 16'($urandom_range(1));
         end else if (kind < 80) begin
            it.cmd  = ($urandom_range(1) != 0) ? CMD_WRITE : CMD_READ;
            it.port = PORT_TAPE;
            if ($urandom_range(1) != 0) it.wdata = 8'd0;
         end else if (kind < 82) begin
            it.cmd = CMD_SYSRST;
         end else begin
            it.cmd = 2'($urandom_range(3));
         end
         send_item(it);
         sent++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      foreach (shadow_vram[i]) shadow_vram[i] = 8'd0;
      foreach (shadow_keys[i]) shadow_keys[i] = BYTE_ONES;
      shadow_overlay = 1'b1;
      shadow_mode    = 8'd0;
      shadow_psg_reg = 5'd0;
      shadow_motor   = 1'b0;
      shadow_pulse   = 1'b0;
      shadow_cfg     = '{1'b1, WIN_LOW_RESET, WIN_HIGH_RESET};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender sparse idling, receiver mostly stalled
      send_idle_pct = 12;
      rsp_idle_pct  = 86;
      test_directed_decode();
      test_check_window();
      test_random_traffic(170);

      // the other way round
      drain_results();
      rsp_idle_pct = 12;
      test_backpressure();
      send_idle_pct = 86;
      test_random_traffic(170);

      // neither side idles
      drain_results();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_traffic(170);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && predicted_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
